/* hw/rtl/elog_pkg.sv */
// shared types, constants and helpers for the event log ring
package elog_pkg;

    // log geometry
    localparam int LOG_DEPTH = 128;
    localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int CODE_W    = 16;
    localparam int STAMP_W   = 32;
    localparam int AGE_W     = 7;
    localparam int COUNT_W   = 8;
    localparam int ENTRY_W   = CODE_W + STAMP_W;
    localparam int CFG_IDX_W = 1;

    // width used for age against count and for the age-to-slot subtract
    localparam int CMP_W     = (CNT_W > AGE_W) ? CNT_W : AGE_W;
    localparam int POS_W     = CMP_W + 2;

    // register reset values
    localparam logic signed [CODE_W-1:0] INFO_FIRST_RST = 16'sd10000;
    localparam logic signed [CODE_W-1:0] WARN_FIRST_RST = 16'sd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_FIRST = 1'b1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 2'd0,
        OP_READ_AGE  = 2'd1,
        OP_READ_ERR  = 2'd2,
        OP_MARK_READ = 2'd3
    } op_t;

    // event classes
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_INFO,
        CLS_WARN,
        CLS_ERR
    } class_t;

    // memory access from the controller
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic [ADDR_W-1:0]  rd_addr;
    } mem_req_t;

    // result beat status from the controller
    typedef struct packed {
        logic             done;
        logic             valid;
        logic             alert;
        logic             mark_valid;
        logic [CNT_W-1:0] count;
    } rsp_t;

    // class an event id, info threshold tested first
    function automatic class_t classify(
        input logic signed [CODE_W-1:0] code,
        input logic signed [CODE_W-1:0] info_first,
        input logic signed [CODE_W-1:0] warn_first
    );
        class_t cls;
        if (code >= info_first)
            cls = CLS_INFO;
        else if (code >= warn_first)
            cls = CLS_WARN;
        else if (code != '0)
            cls = CLS_ERR;
        else
            cls = CLS_NONE;
        return cls;
    endfunction

endpackage

/* hw/rtl/elog_ram.sv */
// generic single-write, single-read ram with registered read data
module elog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/elog_ctrl.sv */
// pointer, count, error mark and threshold control for the event log ring
module elog_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [elog_pkg::OP_W-1:0]            op,
    input  logic signed [elog_pkg::CODE_W-1:0]   event_code,
    input  logic [elog_pkg::STAMP_W-1:0]         stamp,
    input  logic [elog_pkg::AGE_W-1:0]           age_index,
    input  logic                                 cfg_valid,
    input  logic [elog_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic signed [elog_pkg::CODE_W-1:0]   cfg_data,
    output logic                                 busy,
    output logic                                 cfg_ready,
    output elog_pkg::mem_req_t                   mem_req,
    output elog_pkg::rsp_t                       rsp
);

    import elog_pkg::*;

    logic                     accept;
    op_t                      op_in;
    class_t                   cls;
    logic                     age_hit;
    logic [POS_W-1:0]         age_diff;
    logic [POS_W-1:0]         age_wrap;
    logic [ADDR_W-1:0]        age_pos;
    logic                     mark_hit;
    logic                     mark_kept;

    logic [ADDR_W-1:0]        wp_reg,    wp_next;
    logic [CNT_W-1:0]         cnt_reg,   cnt_next;
    logic [ADDR_W-1:0]        mpos_reg,  mpos_next;
    logic                     mvalid_reg, mvalid_next;
    logic                     done_reg,  done_next;
    logic                     valid_reg, valid_next;
    logic                     alert_reg, alert_next;
    logic signed [CODE_W-1:0] info_reg,  info_next;
    logic signed [CODE_W-1:0] warn_reg,  warn_next;

    // one item per cycle, no stall
    assign busy      = 1'b0;
    assign accept    = start & ~busy;
    assign op_in     = op_t'(op);
    // config lands only when no item is taken and no result beat is out
    assign cfg_ready = ~done_reg & ~start;

    // event class of the incoming id
    assign cls = classify(event_code, info_reg, warn_reg);

    // age to slot: newest is one behind the write position
    assign age_hit  = CMP_W'(age_index) < CMP_W'(cnt_reg);
    assign age_diff = POS_W'(wp_reg) - POS_W'(age_index) - POS_W'(1);
    assign age_wrap = age_diff[POS_W-1] ? (age_diff + POS_W'(LOG_DEPTH)) : age_diff;
    assign age_pos  = age_wrap[ADDR_W-1:0];

    // mark dropped when its entry is overwritten
    assign mark_hit  = mvalid_reg & (mpos_reg == wp_reg);
    assign mark_kept = mvalid_reg & ~mark_hit;

    // memory access
    always_comb
    begin
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = wp_reg;
        mem_req.wr_data = {event_code, stamp};
        mem_req.rd_addr = age_pos;
        if (accept)
        begin
            unique case (op_in)
                OP_PUSH:      mem_req.wr_en   = 1'b1;
                OP_READ_AGE:  mem_req.rd_addr = age_pos;
                OP_READ_ERR:  mem_req.rd_addr = mpos_reg;
                OP_MARK_READ: mem_req.rd_addr = age_pos;
                default:      mem_req.rd_addr = age_pos;
            endcase
        end
    end

    // next state of pointers, count and mark
    always_comb
    begin
        wp_next     = wp_reg;
        cnt_next    = cnt_reg;
        mpos_next   = mpos_reg;
        mvalid_next = mvalid_reg;
        done_next   = accept;
        valid_next  = 1'b0;
        alert_next  = 1'b0;
        if (accept)
        begin
            unique case (op_in)
                OP_PUSH:
                begin
                    wp_next = (wp_reg == ADDR_W'(LOG_DEPTH - 1)) ? '0 : wp_reg + ADDR_W'(1);
                    if (cnt_reg < CNT_W'(LOG_DEPTH))
                        cnt_next = cnt_reg + CNT_W'(1);
                    mvalid_next = mark_kept;
                    if ((cls == CLS_ERR) || ((cls == CLS_WARN) && !mark_kept))
                    begin
                        mpos_next   = wp_reg;
                        mvalid_next = 1'b1;
                    end
                    alert_next = (cls == CLS_ERR);
                end
                OP_READ_AGE:  valid_next  = age_hit;
                OP_READ_ERR:  valid_next  = mvalid_reg;
                OP_MARK_READ: mvalid_next = 1'b0;
                default:      valid_next  = 1'b0;
            endcase
        end
    end

    // threshold register writes
    always_comb
    begin
        info_next = info_reg;
        warn_next = warn_reg;
        if (cfg_valid & cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INFO_FIRST: info_next = cfg_data;
                CFG_WARN_FIRST: warn_next = cfg_data;
                default:        info_next = info_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            cnt_reg    <= '0;
            mpos_reg   <= '0;
            mvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            alert_reg  <= 1'b0;
            info_reg   <= INFO_FIRST_RST;
            warn_reg   <= WARN_FIRST_RST;
        end
        else
        begin
            wp_reg     <= wp_next;
            cnt_reg    <= cnt_next;
            mpos_reg   <= mpos_next;
            mvalid_reg <= mvalid_next;
            done_reg   <= done_next;
            valid_reg  <= valid_next;
            alert_reg  <= alert_next;
            info_reg   <= info_next;
            warn_reg   <= warn_next;
        end
    end

    // status of the result beat
    assign rsp.done       = done_reg;
    assign rsp.valid      = valid_reg;
    assign rsp.alert      = alert_reg;
    assign rsp.mark_valid = mvalid_reg;
    assign rsp.count      = cnt_reg;

endmodule

/* hw/rtl/event_log_ring_with_last_error.sv */
// top level of the circular event log with last-error mark
//
// Command channel: an item (op, event_code, stamp, age_index) is taken at a
// rising edge with start high and busy low. busy never rises, so an item can
// be issued every cycle. op selects push, read by age (0 is newest), read of
// the marked last error or warning, or clearing of that mark.
// Result channel: every item gives one result beat in the cycle after it was
// taken, shown for one cycle with done high: read_code, read_stamp,
// entry_valid, stored_count, error_pending and error_alert. The receiver
// cannot hold results off. The beat is timed by the registered read port of
// the log memory; throughput is one item per cycle.
// Configuration: cfg_valid/cfg_ready write channel, index 0 is the info
// threshold, index 1 the warning threshold; cfg_ready is low during a
// result beat and while start is high.
// Reset: rst_n clears the write pointer, the count and the mark, and loads
// the thresholds with 10000 and 1000. Log memory contents are not cleared;
// only written entries are ever returned.
module event_log_ring_with_last_error (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [elog_pkg::OP_W-1:0]            op,
    input  logic signed [elog_pkg::CODE_W-1:0]   event_code,
    input  logic [elog_pkg::STAMP_W-1:0]         stamp,
    input  logic [elog_pkg::AGE_W-1:0]           age_index,
    output logic                                 done,
    output logic signed [elog_pkg::CODE_W-1:0]   read_code,
    output logic [elog_pkg::STAMP_W-1:0]         read_stamp,
    output logic                                 entry_valid,
    output logic [elog_pkg::COUNT_W-1:0]         stored_count,
    output logic                                 error_pending,
    output logic                                 error_alert,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [elog_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic signed [elog_pkg::CODE_W-1:0]   cfg_data
);

    import elog_pkg::*;

    mem_req_t                   mem_req;
    rsp_t                       rsp;
    logic [ENTRY_W-1:0]         rd_data;
    logic [CNT_W+COUNT_W-1:0]   count_ext;

    // pointers, mark and thresholds
    elog_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .event_code (event_code),
        .stamp      (stamp),
        .age_index  (age_index),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .busy       (busy),
        .cfg_ready  (cfg_ready),
        .mem_req    (mem_req),
        .rsp        (rsp)
    );

    // log entries: id over stamp
    elog_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    // result beat, entry fields zero when nothing was returned
    assign count_ext     = {{COUNT_W{1'b0}}, rsp.count};
    assign done          = rsp.done;
    assign entry_valid   = rsp.valid;
    assign read_code     = rsp.valid ? rd_data[ENTRY_W-1 -: CODE_W] : '0;
    assign read_stamp    = rsp.valid ? rd_data[STAMP_W-1:0] : '0;
    assign stored_count  = count_ext[COUNT_W-1:0];
    assign error_pending = rsp.mark_valid;
    assign error_alert   = rsp.alert;

endmodule

/* hw/rtl/elog_chk.sv */
// port-level checks for the event log ring, bound to the top level
module elog_chk (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [elog_pkg::OP_W-1:0]            op,
    input  logic                                 done,
    input  logic                                 entry_valid,
    input  logic [elog_pkg::COUNT_W-1:0]         stored_count,
    input  logic                                 error_pending,
    input  logic                                 error_alert
);

    import elog_pkg::*;

    // each accepted item gives its beat in the next cycle
    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted item gave no result beat");

    // no beat without an item taken the cycle before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without an accepted item");

    // a push never returns an entry and always leaves a nonzero count
    a_push_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(op) == OP_PUSH)) |-> (!entry_valid && (stored_count != '0)))
        else $error("push beat returned an entry or an empty count");

    // a pushed error always holds the mark
    a_alert_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_alert) |-> error_pending)
        else $error("error alert without a pending mark");

    // mark read clears the mark
    a_mark_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(op) == OP_MARK_READ)) |-> !error_pending)
        else $error("mark still pending after mark read");

endmodule

bind event_log_ring_with_last_error elog_chk u_elog_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .done          (done),
    .entry_valid   (entry_valid),
    .stored_count  (stored_count),
    .error_pending (error_pending),
    .error_alert   (error_alert)
);
